FILE: hw/rtl/fully_assoc_lru_hit_miss_counter_top_macros.svh
// Assertion macros used by the checker of the LRU hit/miss counter.
`ifndef FULLY_ASSOC_LRU_HIT_MISS_COUNTER_TOP_MACROS_SVH
`define FULLY_ASSOC_LRU_HIT_MISS_COUNTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define FALRU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("falru: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define FALRU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("falru: next-cycle property failed");

`endif

FILE: hw/rtl/falru_pkg.sv
// Constants shared by the fully associative LRU hit/miss counter and its checker.
`default_nettype none

package falru_pkg;

  localparam int ADDR_W     = 64;
  localparam int LINE_BYTES = 64;
  localparam int LINE_SHIFT = $clog2(LINE_BYTES);
  localparam int TAG_W      = ADDR_W - LINE_SHIFT;

  localparam int ENTRIES    = 64;
  localparam int RANK_W     = $clog2(ENTRIES);
  localparam int USED_W     = RANK_W + 1;

  localparam int CAP_W      = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam int CNT_W      = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

endpackage

`default_nettype wire

FILE: hw/rtl/fully_assoc_lru_hit_miss_counter_top.sv
// Fully associative cache model with LRU replacement that counts accesses and misses.
`default_nettype none

// This block models a fully associative cache of ENTRIES lines with least-recently-used
// replacement and reports, for every byte address it is given, whether the line hit,
// whether a miss pushed out older lines, and the saturating access and miss totals so far.
// Each address goes through an input register and then a result register, and one
// address can be taken on every cycle without gaps while out_ready keeps the result
// register draining. That rate is set by the lookup stage, which compares the line address
// against all stored tags at once and updates every recency rank in the same cycle. The
// capacity register may be rewritten only while the block is empty; a value of zero
// behaves as one line and a value above ENTRIES behaves as ENTRIES. When capacity is
// lowered below the number of lines in use, the next miss drops all the oldest lines that
// no longer fit and reports one eviction. Tags need no clearing after reset: each entry
// has a valid bit that reset clears, so the block can take traffic immediately.
module fully_assoc_lru_hit_miss_counter_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [falru_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [falru_pkg::ADDR_W-1:0] byte_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic                         evicted,
  output logic [falru_pkg::CNT_W-1:0]  access_count,
  output logic [falru_pkg::CNT_W-1:0]  miss_count
);
  import falru_pkg::*;

  // Configuration and cache state.
  logic [CAP_W-1:0]  capacity_lines;
  logic [TAG_W-1:0]  line_tags [ENTRIES];
  logic [ENTRIES-1:0] line_valid;
  logic [RANK_W-1:0] recency_rank [ENTRIES];
  logic [USED_W-1:0] lines_used;

  // Input stage.
  logic              stage_valid;
  logic [ADDR_W-1:0] stage_addr;
  logic              advance;

  // Lookup results for the item in the input stage.
  logic [TAG_W-1:0]   stage_tag;
  logic [ENTRIES-1:0] match;
  logic               lookup_hit;
  logic [RANK_W-1:0]  hit_rank;
  logic [USED_W-1:0]  cap_eff;
  logic [USED_W-1:0]  keep_limit;
  logic               must_evict;
  logic [ENTRIES-1:0] keep;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] slot_onehot;

  logic [ENTRIES-1:0] line_valid_next;
  logic [RANK_W-1:0]  recency_rank_next [ENTRIES];
  logic [USED_W-1:0]  lines_used_next;
  logic [CNT_W-1:0]   access_count_next;
  logic [CNT_W-1:0]   miss_count_next;

  // The input stage moves on whenever the result register is empty or is being drained,
  // so a new transfer can land in the input stage in the same cycle.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_addr <= byte_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_lines <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_lines <= cfg_wdata;
    end
  end

  // Clamp the programmed capacity into the range of built entries.
  always_comb begin
    if (capacity_lines == '0) begin
      cap_eff = USED_W'(1);
    end else if (32'(capacity_lines) > ENTRIES) begin
      cap_eff = USED_W'(ENTRIES);
    end else begin
      cap_eff = USED_W'(capacity_lines);
    end
  end

  assign stage_tag = stage_addr[ADDR_W-1:LINE_SHIFT];

  // Tags are unique among valid lines, so at most one entry matches and the rank of
  // the hit line can be gathered with a plain OR.
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = line_valid[i] && (line_tags[i] == stage_tag);
      if (match[i]) begin
        hit_rank = hit_rank | recency_rank[i];
      end
    end
  end

  assign lookup_hit = |match;

  // Valid ranks are exactly 0..lines_used-1, so evicting until there is room is the
  // same as dropping every line whose rank is at least capacity minus one.
  assign must_evict = !lookup_hit && (lines_used >= cap_eff);
  assign keep_limit = cap_eff - USED_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      keep[i] = line_valid[i] && !(must_evict && ({1'b0, recency_rank[i]} >= keep_limit));
    end
  end

  // The new line goes into the lowest free entry; one is always free after eviction.
  assign free_vec    = ~keep;
  assign slot_onehot = free_vec & (~free_vec + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (lookup_hit) begin
        line_valid_next[i] = line_valid[i];
        if (match[i]) begin
          recency_rank_next[i] = '0;
        end else if (line_valid[i] && (recency_rank[i] < hit_rank)) begin
          recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
        end else begin
          recency_rank_next[i] = recency_rank[i];
        end
      end else begin
        line_valid_next[i] = keep[i] || slot_onehot[i];
        if (slot_onehot[i]) begin
          recency_rank_next[i] = '0;
        end else if (keep[i]) begin
          recency_rank_next[i] = recency_rank[i] + RANK_W'(1);
        end else begin
          recency_rank_next[i] = recency_rank[i];
        end
      end
    end
  end

  always_comb begin
    if (lookup_hit) begin
      lines_used_next = lines_used;
    end else if (must_evict) begin
      lines_used_next = cap_eff;
    end else begin
      lines_used_next = lines_used + USED_W'(1);
    end
  end

  // The result registers double as the running totals.
  assign access_count_next = (access_count == CNT_MAX) ? access_count
                                                       : access_count + CNT_W'(1);
  assign miss_count_next   = (lookup_hit || (miss_count == CNT_MAX)) ? miss_count
                                                                     : miss_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid <= '0;
      lines_used <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else if (advance) begin
      line_valid <= line_valid_next;
      lines_used <= lines_used_next;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= recency_rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (advance && !lookup_hit && slot_onehot[i]) begin
        line_tags[i] <= stage_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      access_count <= '0;
      miss_count   <= '0;
    end else if (advance) begin
      out_valid    <= 1'b1;
      access_count <= access_count_next;
      miss_count   <= miss_count_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit     <= lookup_hit;
      evicted <= must_evict;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/falru_checker.sv
// Port-level checker for the LRU hit/miss counter, bound to the top level.
`default_nettype none

`include "fully_assoc_lru_hit_miss_counter_top_macros.svh"

module falru_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        hit,
  input  logic                        evicted,
  input  logic [falru_pkg::CNT_W-1:0] access_count,
  input  logic [falru_pkg::CNT_W-1:0] miss_count
);
  import falru_pkg::*;

  logic out_xfer;

  assign out_xfer = out_valid && out_ready;

  // A stalled result keeps its contents.
  `FALRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(evicted) && $stable(access_count) && $stable(miss_count))

  // Only a miss can push lines out.
  `FALRU_ASSERT_IMPL(a_hit_no_evict, out_valid && hit, !evicted)

  // Misses are a subset of accesses.
  `FALRU_ASSERT_IMPL(a_miss_le_access, out_valid, miss_count <= access_count)

  // Back-to-back results step the access total by one until it saturates.
  `FALRU_ASSERT_IMPL(a_access_step, out_xfer ##1 out_xfer, (access_count == $past(access_count) + CNT_W'(1)) || ((access_count == CNT_MAX) && ($past(access_count) == CNT_MAX)))

endmodule

bind fully_assoc_lru_hit_miss_counter_top falru_checker u_falru_checker (.*);

`default_nettype wire
